// ----- src/hexagonal_polar_cube_convert_top_assert.svh -----
// assertion macros for the hexagonal polar / cube converter
// used by the top level only, no other dependencies
`ifndef HEXAGONAL_POLAR_CUBE_CONVERT_TOP_ASSERT_SVH
`define HEXAGONAL_POLAR_CUBE_CONVERT_TOP_ASSERT_SVH

// property that must hold whenever the antecedent is true
`define HPC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hpc assertion failed");

// property checked in the cycle after the antecedent
`define HPC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hpc assertion failed");

`endif

// ----- src/hpcc_pkg.sv -----
// shared types, constants and sector tables for the hexagonal polar / cube converter
// no dependencies
package hpcc_pkg;

    localparam int FracBits   = 16;
    localparam int ValueWidth = 32;
    localparam int QueueDepth = 4;

    localparam logic FUNC_FWD = 1'b0;
    localparam logic FUNC_INV = 1'b1;

    // inverse sector codes
    typedef enum logic [2:0] {
        INV_NONE = 3'd0,
        INV_S0   = 3'd1,
        INV_S1   = 3'd2,
        INV_S23  = 3'd3,
        INV_S4   = 3'd4,
        INV_S5   = 3'd5
    } inv_sec_t;

    // sector base coefficient, integer part
    function automatic logic signed [3:0] sec_base(input logic [2:0] s, input logic [1:0] i);
        logic signed [3:0] b;
        b = 4'sd0;
        unique case (s)
            3'd0: b = (i == 2'd0) ? 4'sd1  : (i == 2'd1) ? 4'sd0  : -4'sd1;
            3'd1: b = (i == 2'd0) ? 4'sd1  : (i == 2'd1) ? 4'sd1  : -4'sd2;
            3'd2: b = (i == 2'd0) ? -4'sd1 : (i == 2'd1) ? 4'sd3  : -4'sd2;
            3'd3: b = (i == 2'd0) ? -4'sd4 : (i == 2'd1) ? 4'sd3  : 4'sd1;
            3'd4: b = (i == 2'd0) ? -4'sd4 : (i == 2'd1) ? -4'sd1 : 4'sd5;
            default: b = (i == 2'd0) ? 4'sd1 : (i == 2'd1) ? -4'sd6 : 4'sd5;
        endcase
        return b;
    endfunction

    // sector slope, -1, 0 or +1
    function automatic logic signed [1:0] sec_slope(input logic [2:0] s, input logic [1:0] i);
        logic signed [1:0] d;
        d = 2'sd0;
        unique case (s)
            3'd0: d = (i == 2'd0) ? -2'sd1 : (i == 2'd1) ? 2'sd1  : 2'sd0;
            3'd1: d = (i == 2'd0) ? -2'sd1 : (i == 2'd1) ? 2'sd0  : 2'sd1;
            3'd2: d = (i == 2'd0) ? 2'sd0  : (i == 2'd1) ? -2'sd1 : 2'sd1;
            3'd3: d = (i == 2'd0) ? 2'sd1  : (i == 2'd1) ? -2'sd1 : 2'sd0;
            3'd4: d = (i == 2'd0) ? 2'sd1  : (i == 2'd1) ? 2'sd0  : -2'sd1;
            default: d = (i == 2'd0) ? 2'sd0 : (i == 2'd1) ? 2'sd1 : -2'sd1;
        endcase
        return d;
    endfunction

endpackage

// ----- src/hexagonal_polar_cube_convert_top.sv -----
// Hexagonal polar / cube coordinate converter, top level.
// Slave stream s_axis_*: one transaction per conversion; tuser carries func
// (0 polar to cube with Jacobian, 1 cube to polar), tdata carries
// rho_in, phi_in, x1_in, x2_in, x3_in from bit 0 up.
// Master stream m_axis_*: one result transaction per input transaction,
// in order; tuser carries angle_error.
// Pipe depth is set by the bit-per-stage restoring divider of the inverse
// angle; forward items travel the same pipe to keep order.
// Throughput: one transaction per cycle while the output is taken.
// A four-entry queue sits between the classifying front end and the
// arithmetic back end. When the receiver holds tready low the whole back
// pipe freezes and the queue fills; s_axis_tready drops once it is full.
// Reset clears queue pointers and all pipe valids; no clearing pass.
// depends on hpcc_pkg, hpcc_front, hpcc_back
`include "hexagonal_polar_cube_convert_top_assert.svh"
module hexagonal_polar_cube_convert_top #(
    parameter int FRAC_BITS   = hpcc_pkg::FracBits,
    parameter int VALUE_WIDTH = hpcc_pkg::ValueWidth
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    // rho_in, phi_in, x1_in, x2_in, x3_in from the lowest bit up
    input  logic [5*VALUE_WIDTH-1:0]   s_axis_tdata,
    // func
    input  logic                       s_axis_tuser,
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // x1_out, x2_out, x3_out, dx1..3_drho, dx1..3_dphi, rho_out, phi_out
    output logic [295:0]               m_axis_tdata,
    // angle_error
    output logic                       m_axis_tuser
);
    logic                          q_valid, q_pop, q_func, q_err;
    logic [2:0]                    q_sec;
    logic signed [VALUE_WIDTH-1:0] q_a, q_b, q_c;
    logic signed [31:0] x1, x2, x3, d1, d2, d3;
    logic signed [17:0] c1, c2, c3;
    logic [30:0] rho;
    logic [18:0] phi;

    // front end with queue
    hpcc_front #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .func(s_axis_tuser),
        .rho_in(s_axis_tdata[VALUE_WIDTH-1:0]),
        .phi_in(s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH]),
        .x1_in(s_axis_tdata[3*VALUE_WIDTH-1:2*VALUE_WIDTH]),
        .x2_in(s_axis_tdata[4*VALUE_WIDTH-1:3*VALUE_WIDTH]),
        .x3_in(s_axis_tdata[5*VALUE_WIDTH-1:4*VALUE_WIDTH]),
        .q_valid(q_valid), .q_pop(q_pop), .q_func(q_func), .q_err(q_err),
        .q_sec(q_sec), .q_a(q_a), .q_b(q_b), .q_c(q_c)
    );

    // arithmetic back end
    hpcc_back #(.FRAC_BITS(FRAC_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_func(q_func), .q_err(q_err),
        .q_sec(q_sec), .q_a(q_a), .q_b(q_b), .q_c(q_c),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .x1_out(x1), .x2_out(x2), .x3_out(x3),
        .dx1_drho(c1), .dx2_drho(c2), .dx3_drho(c3),
        .dx1_dphi(d1), .dx2_dphi(d2), .dx3_dphi(d3),
        .rho_out(rho), .phi_out(phi), .angle_error(m_axis_tuser)
    );

    assign m_axis_tdata = {phi, rho, d3, d2, d1, c3, c2, c1, x3, x2, x1};

    // checks
    `HPC_ASSERT_IMP(a_pop_needs_data, q_pop, q_valid)
    `HPC_ASSERT_IMP(a_err_fwd_zero, m_axis_tvalid && m_axis_tuser,
        (x1 == '0) && (rho == '0) && (phi == '0))
    `HPC_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
endmodule

// ----- src/hpcc_front.sv -----
// front end: accepts transactions, classifies sector and pushes a queue entry
// depends on hpcc_pkg
module hpcc_front #(
    parameter int FRAC_BITS   = hpcc_pkg::FracBits,
    parameter int VALUE_WIDTH = hpcc_pkg::ValueWidth,
    parameter int DEPTH       = hpcc_pkg::QueueDepth
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          func,
    input  logic signed [VALUE_WIDTH-1:0] rho_in,
    input  logic signed [VALUE_WIDTH-1:0] phi_in,
    input  logic signed [VALUE_WIDTH-1:0] x1_in,
    input  logic signed [VALUE_WIDTH-1:0] x2_in,
    input  logic signed [VALUE_WIDTH-1:0] x3_in,
    output logic                          q_valid,
    input  logic                          q_pop,
    output logic                          q_func,
    output logic                          q_err,
    output logic [2:0]                    q_sec,
    output logic signed [VALUE_WIDTH-1:0] q_a,
    output logic signed [VALUE_WIDTH-1:0] q_b,
    output logic signed [VALUE_WIDTH-1:0] q_c
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                          func_mem [DEPTH];
    logic                          err_mem  [DEPTH];
    logic [2:0]                    sec_mem  [DEPTH];
    logic signed [VALUE_WIDTH-1:0] a_mem    [DEPTH];
    logic signed [VALUE_WIDTH-1:0] b_mem    [DEPTH];
    logic signed [VALUE_WIDTH-1:0] c_mem    [DEPTH];

    logic [AW-1:0] wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          push;
    logic          err;
    logic [2:0]    sec;
    logic [VALUE_WIDTH-FRAC_BITS-1:0] ipart;
    hpcc_pkg::inv_sec_t isec;

    assign in_ready = (cnt_reg != CW'(DEPTH)) || q_pop;
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);

    // forward range check and sector from the integer part of phi
    always_comb
    begin
        ipart = phi_in[VALUE_WIDTH-1:FRAC_BITS];
        err   = phi_in[VALUE_WIDTH-1] ||
                (phi_in > ($signed({{(VALUE_WIDTH-3){1'b0}}, 3'd6}) <<< FRAC_BITS));
        sec   = (ipart > (VALUE_WIDTH-FRAC_BITS)'(5)) ? 3'd5 : ipart[2:0];
    end

    // inverse sign pattern classification
    always_comb
    begin
        logic p1, p2, p3, n1, n2, n3;
        p1 = !x1_in[VALUE_WIDTH-1] && (x1_in != '0);
        p2 = !x2_in[VALUE_WIDTH-1] && (x2_in != '0);
        p3 = !x3_in[VALUE_WIDTH-1] && (x3_in != '0);
        n1 = x1_in[VALUE_WIDTH-1];
        n2 = x2_in[VALUE_WIDTH-1];
        n3 = x3_in[VALUE_WIDTH-1];
        priority if (p1 && !n2 && n3)      isec = hpcc_pkg::INV_S0;
        else if (!p1 && p2 && n3)          isec = hpcc_pkg::INV_S1;
        else if (n1 && p2 && !n3)          isec = hpcc_pkg::INV_S23;
        else if (n1 && !p2 && p3)          isec = hpcc_pkg::INV_S23;
        else if (!n1 && n2 && p3)          isec = hpcc_pkg::INV_S4;
        else if (p1 && n2 && !p3)          isec = hpcc_pkg::INV_S5;
        else                               isec = hpcc_pkg::INV_NONE;
    end

    // queue pointers
    always_comb
    begin
        wr_next  = push  ? ((wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1) : wr_reg;
        rd_next  = q_pop ? ((rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + CW'(push) - CW'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            func_mem[wr_reg] <= func;
            err_mem[wr_reg]  <= (func == hpcc_pkg::FUNC_FWD) && err;
            sec_mem[wr_reg]  <= (func == hpcc_pkg::FUNC_FWD) ? sec : 3'(isec);
            a_mem[wr_reg]    <= (func == hpcc_pkg::FUNC_FWD) ? rho_in : x1_in;
            b_mem[wr_reg]    <= (func == hpcc_pkg::FUNC_FWD) ? phi_in : x2_in;
            c_mem[wr_reg]    <= x3_in;
        end
    end

    assign q_func = func_mem[rd_reg];
    assign q_err  = err_mem[rd_reg];
    assign q_sec  = sec_mem[rd_reg];
    assign q_a    = a_mem[rd_reg];
    assign q_b    = b_mem[rd_reg];
    assign q_c    = c_mem[rd_reg];
endmodule

// ----- src/hpcc_back.sv -----
// back end: pipelined arithmetic for forward map, Jacobian and inverse angle
// depends on hpcc_pkg
module hpcc_back #(
    parameter int FRAC_BITS   = hpcc_pkg::FracBits,
    parameter int VALUE_WIDTH = hpcc_pkg::ValueWidth
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic                          q_func,
    input  logic                          q_err,
    input  logic [2:0]                    q_sec,
    input  logic signed [VALUE_WIDTH-1:0] q_a,
    input  logic signed [VALUE_WIDTH-1:0] q_b,
    input  logic signed [VALUE_WIDTH-1:0] q_c,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [31:0]            x1_out,
    output logic signed [31:0]            x2_out,
    output logic signed [31:0]            x3_out,
    output logic signed [17:0]            dx1_drho,
    output logic signed [17:0]            dx2_drho,
    output logic signed [17:0]            dx3_drho,
    output logic signed [31:0]            dx1_dphi,
    output logic signed [31:0]            dx2_dphi,
    output logic signed [31:0]            dx3_dphi,
    output logic [30:0]                   rho_out,
    output logic [18:0]                   phi_out,
    output logic                          angle_error
);
    localparam int W   = VALUE_WIDTH;
    localparam int CWD = W + 5;           // coefficient width
    localparam int PW  = W + CWD;         // product width
    localparam int NUM = W + FRAC_BITS;   // dividend width
    localparam int SW  = (W < 32) ? W : 32;
    localparam int NS  = NUM + 2;         // pipeline depth

    // saturation limits
    localparam logic signed [PW-1:0] LIM = PW'((64'sd1 <<< (SW-1)) - 64'sd1);

    // stage valids shift with a global enable: stage 0 plus the NS carried stages
    logic [NS:0]   v_reg;
    logic          adv;
    logic          out_v_reg;

    assign adv       = !out_v_reg || out_ready;
    assign q_pop     = q_valid && adv;
    assign out_valid = out_v_reg;

    // stage 0: coefficients and magnitudes
    logic                    s0_func_reg, s0_err_reg;
    logic [2:0]              s0_sec_reg;
    logic signed [W-1:0]     s0_rho_reg;
    logic signed [CWD-1:0]   s0_c_reg [3];
    logic signed [1:0]       s0_d_reg [3];
    logic [W:0]              s0_r_reg;
    logic [W:0]              s0_m_reg;   // dividend magnitude
    logic                    s0_neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [W:0] m1, m2, m3, r;
            logic signed [CWD-1:0] phis;
            m1 = q_a[W-1] ? (W+1)'(-{q_a[W-1], q_a}) : {1'b0, q_a};
            m2 = q_b[W-1] ? (W+1)'(-{q_b[W-1], q_b}) : {1'b0, q_b};
            m3 = q_c[W-1] ? (W+1)'(-{q_c[W-1], q_c}) : {1'b0, q_c};
            r = m1;
            if (m2 > r) r = m2;
            if (m3 > r) r = m3;
            phis = CWD'(q_b);
            s0_func_reg <= q_func;
            s0_err_reg  <= q_err;
            s0_sec_reg  <= q_sec;
            s0_rho_reg  <= q_a;
            for (int i = 0; i < 3; i++)
            begin
                s0_c_reg[i] <= (CWD'(hpcc_pkg::sec_base(q_sec, 2'(i))) <<< FRAC_BITS)
                    + CWD'(hpcc_pkg::sec_slope(q_sec, 2'(i))) * phis;
                s0_d_reg[i] <= hpcc_pkg::sec_slope(q_sec, 2'(i));
            end
            s0_r_reg <= r;
            unique case (hpcc_pkg::inv_sec_t'(q_sec))
                hpcc_pkg::INV_S0, hpcc_pkg::INV_S23, hpcc_pkg::INV_S5:
                begin
                    s0_m_reg <= m2; s0_neg_reg <= q_b[W-1];
                end
                hpcc_pkg::INV_S1, hpcc_pkg::INV_S4:
                begin
                    s0_m_reg <= m1; s0_neg_reg <= q_a[W-1];
                end
                default:
                begin
                    s0_m_reg <= '0; s0_neg_reg <= 1'b0;
                end
            endcase
        end
    end

    // forward products, then saturation, carried down the pipe
    logic signed [W-1:0]  f_x_reg  [NS][3];
    logic signed [17:0]   f_c_reg  [NS][3];
    logic signed [W-1:0]  f_d_reg  [NS][3];
    logic                 f_func_reg [NS];
    logic                 f_err_reg  [NS];
    logic [2:0]           f_sec_reg  [NS];
    logic [W:0]           f_r_reg    [NS];
    logic                 f_neg_reg  [NS];

    // restoring divider, one quotient bit per stage, last stage passes through
    logic [W:0]           dv_rem_reg [NS];
    logic [NUM-1:0]       dv_num_reg [NS];

    function automatic logic signed [W-1:0] sat(input logic signed [PW-1:0] v);
        if (v > LIM) return W'(LIM);
        if (v < -LIM) return W'(-LIM);
        return W'(v);
    endfunction

    // stage 1: multiply and saturate, start divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [PW-1:0] p;
            for (int i = 0; i < 3; i++)
            begin
                p = PW'(s0_rho_reg) * PW'(s0_c_reg[i]);
                f_x_reg[0][i] <= sat(p >>> FRAC_BITS);
                f_c_reg[0][i] <= 18'(s0_c_reg[i]);
                f_d_reg[0][i] <= sat(PW'(s0_rho_reg) * PW'(s0_d_reg[i]));
            end
            f_func_reg[0] <= s0_func_reg;
            f_err_reg[0]  <= s0_err_reg;
            f_sec_reg[0]  <= s0_sec_reg;
            f_r_reg[0]    <= s0_r_reg;
            f_neg_reg[0]  <= s0_neg_reg;
            dv_rem_reg[0] <= '0;
            dv_num_reg[0] <= {s0_m_reg[W-1:0], {FRAC_BITS{1'b0}}};
        end
    end

    // divider stages
    for (genvar k = 1; k < NS; k++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                logic [W+1:0] t;
                t = {dv_rem_reg[k-1], dv_num_reg[k-1][NUM-1]};
                if ((k <= NUM) && (f_r_reg[k-1] != '0) && (t >= {1'b0, f_r_reg[k-1]}))
                begin
                    dv_rem_reg[k] <= (W+1)'(t - {1'b0, f_r_reg[k-1]});
                    dv_num_reg[k] <= {dv_num_reg[k-1][NUM-2:0], 1'b1};
                end
                else if (k <= NUM)
                begin
                    dv_rem_reg[k] <= (W+1)'(t);
                    dv_num_reg[k] <= {dv_num_reg[k-1][NUM-2:0], 1'b0};
                end
                else
                begin
                    dv_rem_reg[k] <= dv_rem_reg[k-1];
                    dv_num_reg[k] <= dv_num_reg[k-1];
                end
                f_x_reg[k]    <= f_x_reg[k-1];
                f_c_reg[k]    <= f_c_reg[k-1];
                f_d_reg[k]    <= f_d_reg[k-1];
                f_func_reg[k] <= f_func_reg[k-1];
                f_err_reg[k]  <= f_err_reg[k-1];
                f_sec_reg[k]  <= f_sec_reg[k-1];
                f_r_reg[k]    <= f_r_reg[k-1];
                f_neg_reg[k]  <= f_neg_reg[k-1];
            end
        end
    end

    // valid pipeline and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg     <= '0;
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg     <= {v_reg[NS-1:0], q_valid};
            out_v_reg <= v_reg[NS];
        end
    end

    // final assembly into output registers
    logic signed [31:0] x_reg [3];
    logic signed [17:0] c_reg [3];
    logic signed [31:0] d_reg [3];
    logic [30:0] rho_reg;
    logic [18:0] phi_reg;
    logic        err_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic signed [W+2:0] q, off, ph;
            logic fwd, fe;
            fwd = (f_func_reg[NS-1] == hpcc_pkg::FUNC_FWD);
            fe  = f_err_reg[NS-1];
            q   = (W+3)'(dv_num_reg[NS-1][W:0]);
            if (f_neg_reg[NS-1]) q = -q;
            off = '0;
            ph  = '0;
            unique case (hpcc_pkg::inv_sec_t'(f_sec_reg[NS-1]))
                hpcc_pkg::INV_S0:  ph = q;
                hpcc_pkg::INV_S1:
                begin
                    off = (W+3)'(1) <<< FRAC_BITS; ph = off - q;
                end
                hpcc_pkg::INV_S23:
                begin
                    off = (W+3)'(3) <<< FRAC_BITS; ph = off - q;
                end
                hpcc_pkg::INV_S4:
                begin
                    off = (W+3)'(4) <<< FRAC_BITS; ph = off + q;
                end
                hpcc_pkg::INV_S5:
                begin
                    off = (W+3)'(6) <<< FRAC_BITS; ph = off + q;
                end
                default: ph = '0;
            endcase
            for (int i = 0; i < 3; i++)
            begin
                x_reg[i] <= (fwd && !fe) ? 32'(f_x_reg[NS-1][i]) : '0;
                c_reg[i] <= (fwd && !fe) ? f_c_reg[NS-1][i] : '0;
                d_reg[i] <= (fwd && !fe) ? 32'(f_d_reg[NS-1][i]) : '0;
            end
            err_reg <= fwd && fe;
            rho_reg <= fwd ? '0 :
                (f_r_reg[NS-1] > (W+1)'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF : 31'(f_r_reg[NS-1]);
            phi_reg <= fwd ? '0 : 19'(ph);
        end
    end

    assign x1_out = x_reg[0];
    assign x2_out = x_reg[1];
    assign x3_out = x_reg[2];
    assign dx1_drho = c_reg[0];
    assign dx2_drho = c_reg[1];
    assign dx3_drho = c_reg[2];
    assign dx1_dphi = d_reg[0];
    assign dx2_dphi = d_reg[1];
    assign dx3_dphi = d_reg[2];
    assign rho_out = rho_reg;
    assign phi_out = phi_reg;
    assign angle_error = err_reg;
endmodule
